[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("concurrent assertion failed");
// antecedent in a cycle implies consequent in the next cycle
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("concurrent assertion failed");
`else
`define ASSERT_IMPL(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

[design/eps_pkg.sv]
// ----------------------------------------------------------------------------
// eps_pkg
// Constants, types and calendar helpers for the epoch to calendar converter.
// ----------------------------------------------------------------------------
package eps_pkg;

   localparam int WORK_W = 18;               // working remainder width

   localparam int SEC_PER_DAY    = 86400;
   localparam int SEC_PER_HOUR   = 3600;
   localparam int SEC_PER_MIN    = 60;
   localparam int DAYS_PER_WEEK  = 7;
   localparam int EPOCH_WEEKDAY  = 4;        // 1970-01-01 was a Thursday
   localparam int FIRST_YEAR     = 1970;
   localparam int CENTURY_NOLEAP = 2100;
   localparam int LAST_MONTH     = 11;       // December, zero based

   typedef struct packed {
      logic [WORK_W-1:0] diff;
      logic              ge;
   } sub_res_type;

   // Inputs reach only 2106, so 2100 is the one year in range that is
   // divisible by 4 but not leap (2000 is divisible by 400).
   function automatic logic is_leap(input logic [11:0] y);
      is_leap = (y[1:0] == 2'b00) && (y != 12'(CENTURY_NOLEAP));
   endfunction

   function automatic logic [8:0] year_len(input logic [11:0] y);
      year_len = is_leap(y) ? 9'd366 : 9'd365;
   endfunction

   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
      logic [4:0] len;
      unique case (mon)
         4'd1:                      len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      month_len = len;
   endfunction

endpackage

[design/eps_sub_unit.sv]
// ----------------------------------------------------------------------------
// eps_sub_unit
// Shared subtract and compare unit: a - b and a >= b.
// ----------------------------------------------------------------------------
module eps_sub_unit
   import eps_pkg::*;
(
   input  logic [WORK_W-1:0] a,
   input  logic [WORK_W-1:0] b,
   output sub_res_type       res
);

   logic [WORK_W:0] wide;

   assign wide     = {1'b0, a} - {1'b0, b};
   assign res.diff = wide[WORK_W-1:0];
   assign res.ge   = ~wide[WORK_W];

endmodule

[design/epoch_seconds_to_calendar.sv]
// One transfer at a time: the strobe comes once the divisions and the year and
// month search are done; busy drops in the strobe cycle, so the next transfer
// can go at the edge that ends it. One shared subtract/compare unit does the
// restoring divisions (16+5+6+14 steps), then one step per year and per month
// of the calendar search. Reset (synchronous, active high) returns the
// sequencer to idle, no strobe.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Unix epoch seconds to Gregorian date and time, iterative sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epoch_seconds_to_calendar
   import eps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_strobe,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic [2:0]  rsp_weekday,
   output logic [8:0]  rsp_day_of_year
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DAY, ST_HOUR, ST_MIN, ST_WEEK, ST_YEAR, ST_MONTH
   } state_type;

   state_type         state_ff, state_in;
   logic              strobe_ff, strobe_in;
   logic [WORK_W-1:0] rem_ff, rem_in;
   logic [15:0]       src_ff, src_in;
   logic [15:0]       days_ff, days_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [11:0]       year_ff, year_in;
   logic [3:0]        mon_ff, mon_in;
   logic              leap_ff, leap_in;
   logic [4:0]        hour_ff, hour_in;
   logic [5:0]        minute_ff, minute_in;
   logic [5:0]        second_ff, second_in;
   logic [2:0]        weekday_ff, weekday_in;
   logic [8:0]        yday_ff, yday_in;

   logic [WORK_W-1:0] op_a, op_b, kept;
   sub_res_type       sub;
   logic              last;

   eps_sub_unit u_sub (
      .a   (op_a),
      .b   (op_b),
      .res (sub)
   );

   assign last = (cnt_ff == 4'd0);
   assign kept = sub.ge ? sub.diff : op_a;

   // operand selection for the shared unit
   always_comb begin
      op_a = rem_ff;
      op_b = '0;
      unique case (state_ff)
         ST_DAY: begin
            op_a = {rem_ff[WORK_W-2:0], src_ff[15]};
            op_b = WORK_W'(SEC_PER_DAY);
         end
         ST_HOUR:  op_b = WORK_W'(SEC_PER_HOUR) << cnt_ff;
         ST_MIN:   op_b = WORK_W'(SEC_PER_MIN) << cnt_ff;
         ST_WEEK:  op_b = WORK_W'(DAYS_PER_WEEK) << cnt_ff;
         ST_YEAR:  op_b = WORK_W'(year_len(year_ff));
         ST_MONTH: op_b = WORK_W'(month_len(leap_ff, mon_ff));
         default:  op_b = '0;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      strobe_in  = 1'b0;
      rem_in     = rem_ff;
      src_in     = src_ff;
      days_in    = days_ff;
      cnt_in     = cnt_ff;
      year_in    = year_ff;
      mon_in     = mon_ff;
      leap_in    = leap_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      weekday_in = weekday_ff;
      yday_in    = yday_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rem_in   = WORK_W'(req_epoch_seconds[31:16]);
               src_in   = req_epoch_seconds[15:0];
               cnt_in   = 4'd15;
               year_in  = 12'(FIRST_YEAR);
               mon_in   = '0;
               state_in = ST_DAY;
            end
         end
         ST_DAY: begin
            rem_in  = kept;
            src_in  = {src_ff[14:0], 1'b0};
            days_in = {days_ff[14:0], sub.ge};
            cnt_in  = cnt_ff - 4'd1;
            if (last) begin
               cnt_in   = 4'd4;
               state_in = ST_HOUR;
            end
         end
         ST_HOUR: begin
            rem_in  = kept;
            hour_in = {hour_ff[3:0], sub.ge};
            cnt_in  = cnt_ff - 4'd1;
            if (last) begin
               cnt_in   = 4'd5;
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            rem_in    = kept;
            minute_in = {minute_ff[4:0], sub.ge};
            cnt_in    = cnt_ff - 4'd1;
            if (last) begin
               second_in = kept[5:0];
               rem_in    = WORK_W'(days_ff) + WORK_W'(EPOCH_WEEKDAY);
               cnt_in    = 4'd13;
               state_in  = ST_WEEK;
            end
         end
         ST_WEEK: begin
            rem_in = kept;
            cnt_in = cnt_ff - 4'd1;
            if (last) begin
               weekday_in = kept[2:0];
               rem_in     = WORK_W'(days_ff);
               state_in   = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (sub.ge) begin
               rem_in  = sub.diff;
               year_in = year_ff + 12'd1;
            end else begin
               yday_in  = rem_ff[8:0];
               leap_in  = is_leap(year_ff);
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (mon_ff != 4'(LAST_MONTH) && sub.ge) begin
               rem_in = sub.diff;
               mon_in = mon_ff + 4'd1;
            end else begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      src_ff     <= src_in;
      days_ff    <= days_in;
      cnt_ff     <= cnt_in;
      year_ff    <= year_in;
      mon_ff     <= mon_in;
      leap_ff    <= leap_in;
      hour_ff    <= hour_in;
      minute_ff  <= minute_in;
      second_ff  <= second_in;
      weekday_ff <= weekday_in;
      yday_ff    <= yday_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_year         = year_ff;
   assign rsp_month        = mon_ff + 4'd1;
   assign rsp_day_of_month = rem_ff[4:0] + 5'd1;
   assign rsp_hour         = hour_ff;
   assign rsp_minute       = minute_ff;
   assign rsp_second       = second_ff;
   assign rsp_weekday      = weekday_ff;
   assign rsp_day_of_year  = yday_ff;

   `ASSERT_IMPL(a_strobe_idle, clock, reset, strobe_ff, state_ff == ST_IDLE)
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !strobe_ff)
   `ASSERT_NEXT(a_single_strobe, clock, reset, strobe_ff, !strobe_ff)
   `ASSERT_IMPL(a_month_bound, clock, reset, state_ff == ST_MONTH,
                mon_ff <= 4'(LAST_MONTH) && rem_ff < WORK_W'(366))
   `ASSERT_IMPL(a_result_range, clock, reset, strobe_ff,
                rsp_weekday < 3'd7 && rsp_hour < 5'd24 && rsp_day_of_year < 9'd366)

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives epoch second counts into the calendar converter one transfer at a
// time and checks every strobed date/time against an in-bench calendar
// computation: corner dates first, then random counts with idle bursts.
// ----------------------------------------------------------------------------
module testbench
   import eps_pkg::*;
;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  mday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  wday;
      logic [8:0]  yday;
   } calendar_type;

   localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   // leap days, year ends, the 2100 non-leap century, the 2038 rollover,
   // alternating bit patterns and the top of the range
   localparam logic [31:0] CORNER_SECONDS [22] = '{
      32'd0,          32'd1,          32'd59,         32'd60,
      32'd3599,       32'd3600,       32'd86399,      32'd86400,
      32'd31535999,   32'd68169600,   32'd94607999,   32'd951782400,
      32'd978307199,  32'd2147483647, 32'd2147483648, 32'd4102444799,
      32'd4107542399, 32'd4107542400, 32'd4133980799, 32'hAAAAAAAA,
      32'h55555555,   32'hFFFFFFFF
   };

   localparam int RANDOM_ITEMS = 880;
   localparam int QUIET_TAIL   = 100;   // last items run without idling
   localparam int DRAIN_CYCLES = 200;

   class calendar_ledger;
      calendar_type due_dates[$];
      int           mismatches = 0;

      static function bit leap_year(int unsigned y);
         return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      endfunction

      static function calendar_type calendar_of(logic [31:0] secs);
         int unsigned  s, tod, days, yr, mon, mlen, ylen;
         bit           leap;
         calendar_type d;
         s    = secs;
         tod  = s % SEC_PER_DAY;
         days = s / SEC_PER_DAY;
         d.hour   = 5'(tod / SEC_PER_HOUR);
         d.minute = 6'((tod % SEC_PER_HOUR) / SEC_PER_MIN);
         d.second = 6'(tod % SEC_PER_MIN);
         d.wday   = 3'((days + EPOCH_WEEKDAY) % DAYS_PER_WEEK);
         yr = FIRST_YEAR;
         forever begin
            ylen = leap_year(yr) ? 366 : 365;
            if (days < ylen) break;
            days -= ylen;
            yr++;
         end
         d.yday = 9'(days);
         leap = leap_year(yr);
         mon = 0;
         while (mon < LAST_MONTH) begin
            mlen = MONTH_DAYS[mon] + ((mon == 1 && leap) ? 1 : 0);
            if (days < mlen) break;
            days -= mlen;
            mon++;
         end
         d.year  = 12'(yr);
         d.month = 4'(mon + 1);
         d.mday  = 5'(days + 1);
         return d;
      endfunction

      function void note_seconds(logic [31:0] secs);
         due_dates.push_back(calendar_of(secs));
      endfunction

      function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
         if (got === want) return 1'b1;
         $error("%s expected %0d got %0d", name, want, got);
         return 1'b0;
      endfunction

      function void check_date(calendar_type got);
         calendar_type want;
         bit           ok;
         if (due_dates.size() == 0) begin
            $error("result strobe with no transfer outstanding");
            mismatches++;
            return;
         end
         want = due_dates.pop_front();
         ok = field_ok("year", want.year, got.year)
            & field_ok("month", want.month, got.month)
            & field_ok("day_of_month", want.mday, got.mday)
            & field_ok("hour", want.hour, got.hour)
            & field_ok("minute", want.minute, got.minute)
            & field_ok("second", want.second, got.second)
            & field_ok("weekday", want.wday, got.wday)
            & field_ok("day_of_year", want.yday, got.yday);
         if (!ok) mismatches++;
      endfunction

      function bit clean();
         if (due_dates.size() != 0) begin
            $error("%0d results never arrived", due_dates.size());
            mismatches++;
         end
         return mismatches == 0;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [31:0] req_epoch_seconds = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic [2:0]  rsp_weekday;
   logic [8:0]  rsp_day_of_year;

   calendar_ledger ledger;

   epoch_seconds_to_calendar uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_epoch_seconds(req_epoch_seconds),
      .rsp_strobe       (rsp_strobe),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .rsp_weekday      (rsp_weekday),
      .rsp_day_of_year  (rsp_day_of_year)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         ledger.check_date('{rsp_year, rsp_month, rsp_day_of_month, rsp_hour,
                             rsp_minute, rsp_second, rsp_weekday, rsp_day_of_year});
   end

   // One transfer. An idle burst either starts right at the previous
   // transfer or once busy has dropped, so gaps land on both phases.
   task automatic transfer_seconds(input logic [31:0] secs, input bit idling);
      if (idling && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         if ($urandom_range(0, 1)) begin
            do @(posedge clock); while (busy);
         end
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      start <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (busy);
      ledger.note_seconds(secs);
   endtask

   // Half plain random counts, half near midnight of a random day so that
   // month and year ends come up often.
   function automatic logic [31:0] pick_seconds();
      longint unsigned days, offset;
      if ($urandom_range(0, 1)) return $urandom;
      days   = $urandom_range(0, 49710);
      offset = $urandom_range(0, 1) ? $urandom_range(0, 2) : 86399 - $urandom_range(0, 2);
      return 32'(days * SEC_PER_DAY + offset);
   endfunction

   initial begin
      int unsigned run_left;
      bit          idling;
      ledger = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (CORNER_SECONDS[i]) transfer_seconds(CORNER_SECONDS[i], 1'b0);
      run_left = 0;
      idling   = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(10, 60);
            idling   = $urandom_range(0, 2) != 0;
         end
         run_left--;
         transfer_seconds(pick_seconds(), idling && n < RANDOM_ITEMS - QUIET_TAIL);
      end
      start <= 1'b0;
      while (ledger.due_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.clean())
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
